[hdl/bmad_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmad_pkg
// Shared constants and types of the banked memory address decoder: region
// codes, register indexes, video bank geometry and fixed map addresses.
// ----------------------------------------------------------------------------
package bmad_pkg;

  localparam int MAIN_RAM_BYTES_DEF = 4194304;

  localparam int ADDR_W   = 32;
  localparam int REGION_W = 5;
  localparam int OFFSET_W = 22;
  localparam int CFG_AW   = 6;
  localparam int CFG_DW   = 64;
  localparam int BANK_N   = 9;

  localparam logic [REGION_W-1:0] REG_NONE   = 5'd0;
  localparam logic [REGION_W-1:0] REG_ITCM   = 5'd1;
  localparam logic [REGION_W-1:0] REG_DTCM   = 5'd2;
  localparam logic [REGION_W-1:0] REG_MAIN   = 5'd3;
  localparam logic [REGION_W-1:0] REG_SHARED = 5'd4;
  localparam logic [REGION_W-1:0] REG_PAL_A  = 5'd5;
  localparam logic [REGION_W-1:0] REG_VRAM_A = 5'd7;
  localparam logic [REGION_W-1:0] REG_OAM_A  = 5'd16;
  localparam logic [REGION_W-1:0] REG_BIOS0  = 5'd18;
  localparam logic [REGION_W-1:0] REG_BIOS1  = 5'd19;
  localparam logic [REGION_W-1:0] REG_LOCAL  = 5'd20;

  localparam logic [2:0] CFG_VCTL_LO  = 3'd0;
  localparam logic [2:0] CFG_VCTL_HI  = 3'd1;
  localparam logic [2:0] CFG_SPLIT    = 3'd2;
  localparam logic [2:0] CFG_ITCM_ON  = 3'd3;
  localparam logic [2:0] CFG_ITCM_LIM = 3'd4;
  localparam logic [2:0] CFG_DTCM_ON  = 3'd5;
  localparam logic [2:0] CFG_DTCM_BASE = 3'd6;
  localparam logic [2:0] CFG_DTCM_LEN = 3'd7;

  localparam logic [1:0] SPLIT_ALL_MAIN = 2'd0;
  localparam logic [1:0] SPLIT_HI_MAIN  = 2'd1;
  localparam logic [1:0] SPLIT_LO_MAIN  = 2'd2;
  localparam logic [1:0] SPLIT_ALL_SUB  = 2'd3;

  localparam logic [ADDR_W-1:0] VRAM_BG_MAIN  = 32'h0600_0000;
  localparam logic [ADDR_W-1:0] VRAM_BG_SUB   = 32'h0620_0000;
  localparam logic [ADDR_W-1:0] VRAM_OBJ_MAIN = 32'h0640_0000;
  localparam logic [ADDR_W-1:0] VRAM_OBJ_SUB  = 32'h0660_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_A   = 32'h0680_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_B   = 32'h0682_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_C   = 32'h0684_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_D   = 32'h0686_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_E   = 32'h0688_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_F   = 32'h0689_0000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_G   = 32'h0689_4000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_H   = 32'h0689_8000;
  localparam logic [ADDR_W-1:0] VRAM_LCDC_I   = 32'h068A_0000;
  localparam logic [ADDR_W-1:0] VRAM_SUB_I    = 32'h0620_8000;

  localparam logic [7:0]  PAGE_MAIN   = 8'h02;
  localparam logic [7:0]  PAGE_SHARED = 8'h03;
  localparam logic [7:0]  PAGE_PAL    = 8'h05;
  localparam logic [7:0]  PAGE_VRAM   = 8'h06;
  localparam logic [7:0]  PAGE_OAM    = 8'h07;
  localparam logic [16:0] BIOS0_PAGE  = 17'h1FFFE;

  localparam int BANK_LOG [BANK_N] = '{17, 17, 17, 17, 16, 14, 14, 15, 14};

  localparam logic [16:0] BANK_OFS_MASK [BANK_N] = '{
    17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h0FFFF,
    17'h03FFF, 17'h03FFF, 17'h07FFF, 17'h03FFF
  };

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] base;
  } bank_cfg_t;

  typedef struct packed {
    logic              itcm;
    logic              dtcm;
    logic              main_rng;
    logic              shared_rng;
    logic              shared_lo;
    logic              pal_rng;
    logic              video_rng;
    logic              oam_rng;
    logic              bios0_rng;
    logic              bios1_rng;
    logic [BANK_N-1:0] bank;
  } dec_flags_t;

endpackage
`default_nettype wire

[hdl/banked_memory_address_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// banked_memory_address_decoder
// Decodes one processor byte address per cycle into hit, region code and byte
// offset, for either processor map, with TCM windows, shared RAM split and
// nine programmable video banks.
// ----------------------------------------------------------------------------
// Accepts one address in every cycle: busy stays low. A transaction accepted
// at a clock edge shows its result, marked by out_strobe, for exactly one
// cycle after it passes the stage 2, 3, 4 and output registers. The depth
// of the pipeline is set by the main RAM offset reduction (address modulo
// MAIN_RAM_BYTES), done by a reciprocal multiply, a back multiply, a
// subtract and one correction, each behind its own register. Results leave
// at the rate addresses enter; the receiver cannot stall the block. Register
// writes apply to transactions accepted from the next cycle on.
module banked_memory_address_decoder #(
  parameter int MAIN_RAM_BYTES = bmad_pkg::MAIN_RAM_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_which_cpu,
  input  wire logic [bmad_pkg::ADDR_W-1:0]   in_address,

  output logic                               out_strobe,
  output logic                               out_hit,
  output logic [bmad_pkg::REGION_W-1:0]      out_region,
  output logic [bmad_pkg::OFFSET_W-1:0]      out_offset,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bmad_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bmad_pkg::CFG_DW-1:0]   pwdata,
  output logic [bmad_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);
  import bmad_pkg::*;

  localparam int MOD_X_W   = 26;
  localparam int MOD_SHIFT = 42;
  localparam int MAIN_LOG  = $clog2(MAIN_RAM_BYTES);
  localparam int RECIP_W   = 43 - MAIN_LOG;
  localparam int Q_W       = 27 - MAIN_LOG;
  localparam int PROD_W    = MOD_X_W + RECIP_W;
  localparam int QN_W      = Q_W + MOD_X_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << MOD_SHIFT) / 64'(MAIN_RAM_BYTES);
  localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [MOD_X_W-1:0] MAIN_N    = MOD_X_W'(MAIN_RAM_BYTES);

  function automatic bank_cfg_t bank_decode(input logic [3:0] b, input logic [7:0] ctl);
    bank_cfg_t         r;
    logic [2:0]        m3;
    logic [1:0]        m2;
    logic [1:0]        ofs;
    logic [ADDR_W-1:0] ofs128;
    logic [ADDR_W-1:0] fg;
    m3     = ctl[2:0];
    m2     = ctl[1:0];
    ofs    = ctl[4:3];
    ofs128 = ADDR_W'(ofs) << 17;
    fg     = (ADDR_W'(ofs[0]) << 14) + (ADDR_W'(ofs[1]) << 16);
    r.en   = 1'b0;
    r.base = '0;
    case (b)
      4'd0, 4'd1: begin
        r.en = 1'b1;
        case (m2)
          2'd0:    r.base = (b == 4'd0) ? VRAM_LCDC_A : VRAM_LCDC_B;
          2'd1:    r.base = VRAM_BG_MAIN + ofs128;
          2'd2:    r.base = VRAM_OBJ_MAIN + (ADDR_W'(ofs[0]) << 17);
          default: r.en = 1'b0;
        endcase
      end
      4'd2, 4'd3: begin
        r.en = 1'b1;
        case (m3)
          3'd0:    r.base = (b == 4'd2) ? VRAM_LCDC_C : VRAM_LCDC_D;
          3'd1:    r.base = VRAM_BG_MAIN + ofs128;
          3'd4:    r.base = (b == 4'd2) ? VRAM_BG_SUB : VRAM_OBJ_SUB;
          default: r.en = 1'b0;
        endcase
      end
      4'd4: begin
        r.en = 1'b1;
        case (m3)
          3'd0:    r.base = VRAM_LCDC_E;
          3'd1:    r.base = VRAM_BG_MAIN;
          3'd2:    r.base = VRAM_OBJ_MAIN;
          default: r.en = 1'b0;
        endcase
      end
      4'd5, 4'd6: begin
        r.en = 1'b1;
        case (m3)
          3'd0:    r.base = (b == 4'd5) ? VRAM_LCDC_F : VRAM_LCDC_G;
          3'd1:    r.base = VRAM_BG_MAIN + fg;
          3'd2:    r.base = VRAM_OBJ_MAIN + fg;
          default: r.en = 1'b0;
        endcase
      end
      4'd7: begin
        r.en = 1'b1;
        case (m2)
          2'd0:    r.base = VRAM_LCDC_H;
          2'd1:    r.base = VRAM_BG_SUB;
          default: r.en = 1'b0;
        endcase
      end
      4'd8: begin
        r.en = 1'b1;
        case (m2)
          2'd0:    r.base = VRAM_LCDC_I;
          2'd1:    r.base = VRAM_SUB_I;
          2'd2:    r.base = VRAM_OBJ_SUB;
          default: r.en = 1'b0;
        endcase
      end
      default: r.en = 1'b0;
    endcase
    r.en = r.en & ctl[7];
    return r;
  endfunction

  // configuration registers
  logic [31:0] vctl_lo_r;
  logic [39:0] vctl_hi_r;
  logic [1:0]  split_r;
  logic        itcm_on_r;
  logic [31:0] itcm_limit_r;
  logic        dtcm_on_r;
  logic [31:0] dtcm_start_r;
  logic [31:0] dtcm_length_r;
  logic [32:0] dtcm_end_r;
  logic [32:0] dtcm_end_nxt;
  bank_cfg_t   bank_cfg_r   [BANK_N];
  bank_cfg_t   bank_cfg_nxt [BANK_N];

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vctl_lo_r     <= '0;
      vctl_hi_r     <= '0;
      split_r       <= SPLIT_ALL_SUB;
      itcm_on_r     <= 1'b0;
      itcm_limit_r  <= '0;
      dtcm_on_r     <= 1'b0;
      dtcm_start_r  <= '0;
      dtcm_length_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_VCTL_LO:   vctl_lo_r     <= pwdata[31:0];
        CFG_VCTL_HI:   vctl_hi_r     <= pwdata[39:0];
        CFG_SPLIT:     split_r       <= pwdata[1:0];
        CFG_ITCM_ON:   itcm_on_r     <= pwdata[0];
        CFG_ITCM_LIM:  itcm_limit_r  <= pwdata[31:0];
        CFG_DTCM_ON:   dtcm_on_r     <= pwdata[0];
        CFG_DTCM_BASE: dtcm_start_r  <= pwdata[31:0];
        CFG_DTCM_LEN:  dtcm_length_r <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_VCTL_LO:   prdata = CFG_DW'(vctl_lo_r);
      CFG_VCTL_HI:   prdata = CFG_DW'(vctl_hi_r);
      CFG_SPLIT:     prdata = CFG_DW'(split_r);
      CFG_ITCM_ON:   prdata = CFG_DW'(itcm_on_r);
      CFG_ITCM_LIM:  prdata = CFG_DW'(itcm_limit_r);
      CFG_DTCM_ON:   prdata = CFG_DW'(dtcm_on_r);
      CFG_DTCM_BASE: prdata = CFG_DW'(dtcm_start_r);
      CFG_DTCM_LEN:  prdata = CFG_DW'(dtcm_length_r);
    endcase
  end

  // derived decode state, registered and refreshed in the cycle after a write
  assign dtcm_end_nxt = {1'b0, dtcm_start_r} + {1'b0, dtcm_length_r};

  for (genvar g = 0; g < BANK_N; g++) begin : g_bank_cfg
    if (g < 4) begin : g_lo
      assign bank_cfg_nxt[g] = bank_decode(4'(g), vctl_lo_r[8*g +: 8]);
    end else begin : g_hi
      assign bank_cfg_nxt[g] = bank_decode(4'(g), vctl_hi_r[8*(g-4) +: 8]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bank_cfg_r[g] <= '0;
      end else begin
        bank_cfg_r[g] <= bank_cfg_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtcm_end_r <= '0;
    end else begin
      dtcm_end_r <= dtcm_end_nxt;
    end
  end

  // stage 1: capture transaction
  logic              in_fire;
  logic              s1_vld_r;
  logic              s1_cpu_r;
  logic [ADDR_W-1:0] s1_addr_r;

  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_cpu_r  <= in_which_cpu;
    s1_addr_r <= in_address;
  end

  // stage 2: range compares, reciprocal multiply
  dec_flags_t        flags_nxt;
  logic [BANK_N-1:0] bank_hit;
  logic [PROD_W-1:0] prod_nxt;
  logic              s2_vld_r;
  logic              s2_cpu_r;
  logic [ADDR_W-1:0] s2_addr_r;
  dec_flags_t        s2_flags_r;
  logic [PROD_W-1:0] s2_prod_r;

  for (genvar g = 0; g < BANK_N; g++) begin : g_bank_hit
    localparam int L = BANK_LOG[g];
    assign bank_hit[g] = bank_cfg_r[g].en &
                         (s1_addr_r[ADDR_W-1:L] == bank_cfg_r[g].base[ADDR_W-1:L]);
  end

  always_comb begin
    flags_nxt.itcm       = itcm_on_r & (s1_addr_r < itcm_limit_r);
    flags_nxt.dtcm       = dtcm_on_r & (s1_addr_r >= dtcm_start_r) &
                           ({1'b0, s1_addr_r} < dtcm_end_r);
    flags_nxt.main_rng   = s1_addr_r[31:24] == PAGE_MAIN;
    flags_nxt.shared_rng = s1_addr_r[31:24] == PAGE_SHARED;
    flags_nxt.shared_lo  = (s1_addr_r[31:24] == PAGE_SHARED) & ~s1_addr_r[23];
    flags_nxt.pal_rng    = s1_addr_r[31:24] == PAGE_PAL;
    flags_nxt.video_rng  = (s1_addr_r[31:24] == PAGE_PAL) |
                           (s1_addr_r[31:24] == PAGE_VRAM) |
                           (s1_addr_r[31:24] == PAGE_OAM);
    flags_nxt.oam_rng    = s1_addr_r[31:24] == PAGE_OAM;
    flags_nxt.bios0_rng  = s1_addr_r[31:15] == BIOS0_PAGE;
    flags_nxt.bios1_rng  = s1_addr_r[31:14] == '0;
    flags_nxt.bank       = bank_hit;
  end

  assign prod_nxt = PROD_W'(s1_addr_r[MOD_X_W-1:0]) * PROD_W'(MOD_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_cpu_r   <= s1_cpu_r;
    s2_addr_r  <= s1_addr_r;
    s2_flags_r <= flags_nxt;
    s2_prod_r  <= prod_nxt;
  end

  // stage 3: priority select, back multiply
  logic [REGION_W-1:0] region_nxt;
  logic [OFFSET_W-1:0] off_nxt;
  logic [13:0]         dtcm_off;
  logic [14:0]         shared_off0;
  logic [14:0]         shared_off1;
  logic                bank_any;
  logic [REGION_W-1:0] bank_region;
  logic [16:0]         bank_off;
  logic [Q_W-1:0]      quot;
  logic [QN_W-1:0]     qn_full;
  logic                s3_vld_r;
  logic [REGION_W-1:0] s3_region_r;
  logic [OFFSET_W-1:0] s3_off_r;
  logic [MOD_X_W-1:0]  s3_x_r;
  logic [MOD_X_W-1:0]  s3_qn_r;

  assign dtcm_off = s2_addr_r[13:0] - dtcm_start_r[13:0];

  always_comb begin
    unique case (split_r)
      SPLIT_ALL_MAIN: shared_off0 = s2_addr_r[14:0];
      SPLIT_HI_MAIN:  shared_off0 = {1'b1, s2_addr_r[13:0]};
      SPLIT_LO_MAIN:  shared_off0 = {1'b0, s2_addr_r[13:0]};
      SPLIT_ALL_SUB:  shared_off0 = '0;
    endcase
    unique case (split_r)
      SPLIT_ALL_MAIN: shared_off1 = '0;
      SPLIT_HI_MAIN:  shared_off1 = {1'b0, s2_addr_r[13:0]};
      SPLIT_LO_MAIN:  shared_off1 = {1'b1, s2_addr_r[13:0]};
      SPLIT_ALL_SUB:  shared_off1 = s2_addr_r[14:0];
    endcase
  end

  always_comb begin
    bank_any    = 1'b0;
    bank_region = REG_NONE;
    bank_off    = '0;
    for (int b = BANK_N - 1; b >= 0; b--) begin
      if (s2_flags_r.bank[b]) begin
        bank_any    = 1'b1;
        bank_region = REG_VRAM_A + REGION_W'(b);
        bank_off    = s2_addr_r[16:0] & BANK_OFS_MASK[b];
      end
    end
  end

  always_comb begin
    region_nxt = REG_NONE;
    off_nxt    = '0;
    if (!s2_cpu_r) begin
      priority if (s2_flags_r.itcm) begin
        region_nxt = REG_ITCM;
        off_nxt    = OFFSET_W'(s2_addr_r[14:0]);
      end else if (s2_flags_r.dtcm) begin
        region_nxt = REG_DTCM;
        off_nxt    = OFFSET_W'(dtcm_off);
      end else if (s2_flags_r.main_rng) begin
        region_nxt = REG_MAIN;
      end else if (s2_flags_r.shared_rng && split_r != SPLIT_ALL_SUB) begin
        region_nxt = REG_SHARED;
        off_nxt    = OFFSET_W'(shared_off0);
      end else if (s2_flags_r.video_rng) begin
        priority if (s2_flags_r.pal_rng) begin
          region_nxt = REG_PAL_A + REGION_W'(s2_addr_r[10]);
          off_nxt    = OFFSET_W'(s2_addr_r[9:0]);
        end else if (bank_any) begin
          region_nxt = bank_region;
          off_nxt    = OFFSET_W'(bank_off);
        end else if (s2_flags_r.oam_rng) begin
          region_nxt = REG_OAM_A + REGION_W'(s2_addr_r[10]);
          off_nxt    = OFFSET_W'(s2_addr_r[9:0]);
        end
      end else if (s2_flags_r.bios0_rng) begin
        region_nxt = REG_BIOS0;
        off_nxt    = OFFSET_W'(s2_addr_r[14:0]);
      end
    end else begin
      priority if (s2_flags_r.bios1_rng) begin
        region_nxt = REG_BIOS1;
        off_nxt    = OFFSET_W'(s2_addr_r[13:0]);
      end else if (s2_flags_r.main_rng) begin
        region_nxt = REG_MAIN;
      end else if (s2_flags_r.shared_lo && split_r != SPLIT_ALL_MAIN) begin
        region_nxt = REG_SHARED;
        off_nxt    = OFFSET_W'(shared_off1);
      end else if (s2_flags_r.shared_rng) begin
        region_nxt = REG_LOCAL;
        off_nxt    = OFFSET_W'(s2_addr_r[15:0]);
      end
    end
  end

  assign quot    = s2_prod_r[MOD_SHIFT +: Q_W];
  assign qn_full = QN_W'(quot) * QN_W'(MAIN_N);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_region_r <= region_nxt;
    s3_off_r    <= off_nxt;
    s3_x_r      <= s2_addr_r[MOD_X_W-1:0];
    s3_qn_r     <= qn_full[MOD_X_W-1:0];
  end

  // stage 4: partial remainder
  logic                s4_vld_r;
  logic [REGION_W-1:0] s4_region_r;
  logic [OFFSET_W-1:0] s4_off_r;
  logic [MOD_X_W-1:0]  s4_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_region_r <= s3_region_r;
    s4_off_r    <= s3_off_r;
    s4_rem_r    <= s3_x_r - s3_qn_r;
  end

  // output: remainder correction and final offset
  logic [MOD_X_W-1:0]  rem_fix;
  logic                out_strobe_r;
  logic                out_hit_r;
  logic [REGION_W-1:0] out_region_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [OFFSET_W-1:0] out_offset_nxt;

  assign rem_fix        = (s4_rem_r >= MAIN_N) ? (s4_rem_r - MAIN_N) : s4_rem_r;
  assign out_offset_nxt = (s4_region_r == REG_MAIN) ? rem_fix[OFFSET_W-1:0] : s4_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r    <= s4_region_r != REG_NONE;
    out_region_r <= s4_region_r;
    out_offset_r <= out_offset_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r;
  assign out_region = out_region_r;
  assign out_offset = out_offset_r;

endmodule
`default_nettype wire
